// ===== rtl/core/eds_pkg.sv =====
// Shared types, constants and a helper function for the encoder detent setpoint block.
`timescale 1ns / 1ps

package eds_pkg;

  localparam int CfgW     = 16;
  localparam int IdxW     = 3;
  localparam int DivW     = 17;
  localparam int DivSteps = 17;
  localparam int CntW     = 5;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] position;
    logic        edit_current;
    logic        coarse_mode;
    logic [9:0]  load_value;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         voltage_setpoint;
    logic [9:0]         current_setpoint;
    logic signed [15:0] detent_count;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_LOAD_VOLT = 2'd1,
    CMD_LOAD_CURR = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_e;

  typedef enum logic [IdxW-1:0] {
    REG_COUNTER_MAX  = 3'd0,
    REG_CPD          = 3'd1,
    REG_REVERSE      = 3'd2,
    REG_VOLT_FINE    = 3'd3,
    REG_VOLT_COARSE  = 3'd4,
    REG_CURR_FINE    = 3'd5,
    REG_CURR_COARSE  = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_SAT,
    ST_MUL,
    ST_APPLY
  } state_e;

  typedef struct packed {
    logic accept;
    logic prep;
    logic div_step;
    logic sat;
    logic mul;
    logic commit;
  } dp_cmd_t;

  function automatic logic [9:0] clamp_set(input logic signed [27:0] v,
                                           input logic [9:0] lo,
                                           input logic [9:0] hi);
    logic signed [27:0] t;
    logic signed [27:0] lo_s;
    logic signed [27:0] hi_s;
    lo_s = $signed({18'b0, lo});
    hi_s = $signed({18'b0, hi});
    t = v;
    if (t < lo_s) t = lo_s;
    if (t > hi_s) t = hi_s;
    if (t < 28'sd0) t = 28'sd0;
    return t[9:0];
  endfunction

endpackage

// ===== rtl/core/eds_ctrl.sv =====
// Sequencing state machine: accept, wrap fix, divide, saturate, scale, apply.
`timescale 1ns / 1ps

module eds_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_sample_i,
  input  logic             out_ready_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output eds_pkg::dp_cmd_t cmd_o
);
  import eds_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = in_sample_i ? ST_PREP : ST_APPLY;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = ST_SAT;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_APPLY;
      end
      ST_APPLY: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/eds_datapath.sv =====
// Datapath: config registers, wrap correction, serial divider, scaling and clamping.
`timescale 1ns / 1ps

module eds_datapath #(
  parameter int VOLT_MIN = 0,
  parameter int VOLT_MAX = 100,
  parameter int CURR_MIN = 0,
  parameter int CURR_MAX = 100,
  parameter int PosW     = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [eds_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [eds_pkg::CfgW-1:0] cfg_wdata_i,
  input  eds_pkg::in_item_t        in_data_i,
  input  eds_pkg::dp_cmd_t         cmd_i,
  output logic                     in_sample_o,
  output eds_pkg::out_item_t       out_data_o
);
  import eds_pkg::*;

  localparam logic [9:0] VoltLo = 10'(VOLT_MIN);
  localparam logic [9:0] VoltHi = 10'(VOLT_MAX);
  localparam logic [9:0] CurrLo = 10'(CURR_MIN);
  localparam logic [9:0] CurrHi = 10'(CURR_MAX);

  // configuration
  logic [15:0] cm_q;
  logic [8:0]  cpd_q;
  logic        rev_q;
  logic [6:0]  vf_q, vc_q;
  logic [9:0]  cf_q, cc_q;

  // architectural state
  logic [PosW-1:0]    prev_pos_q;
  logic signed [17:0] residue_q;
  logic [9:0]         volt_q, curr_q;

  // per-item working registers
  in_item_t           item_q;
  logic signed [17:0] delta_q;
  logic [DivW-1:0]    dq_q;
  logic [8:0]         rem_q;
  logic               neg_q;
  logic signed [15:0] detents_q;
  logic signed [26:0] product_q;
  out_item_t          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_q  <= 16'hFFFF;
      cpd_q <= 9'd4;
      rev_q <= 1'b0;
      vf_q  <= 7'd1;
      vc_q  <= 7'd10;
      cf_q  <= 10'd1;
      cc_q  <= 10'd10;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_COUNTER_MAX: cm_q  <= cfg_wdata_i[15:0];
        REG_CPD:         cpd_q <= cfg_wdata_i[8:0];
        REG_REVERSE:     rev_q <= cfg_wdata_i[0];
        REG_VOLT_FINE:   vf_q  <= cfg_wdata_i[6:0];
        REG_VOLT_COARSE: vc_q  <= cfg_wdata_i[6:0];
        REG_CURR_FINE:   cf_q  <= cfg_wdata_i[9:0];
        REG_CURR_COARSE: cc_q  <= cfg_wdata_i[9:0];
        default: begin
        end
      endcase
    end
  end

  assign in_sample_o = (in_data_i.command == CMD_SAMPLE);

  // raw delta against the previous reading
  logic [15:0]        pos_ext, prev_ext;
  logic signed [17:0] delta_d;
  assign pos_ext  = 16'(in_data_i.position[PosW-1:0]);
  assign prev_ext = 16'(prev_pos_q);
  assign delta_d  = $signed({2'b00, pos_ext} - {2'b00, prev_ext});

  // wrap correction and residue add
  logic signed [17:0] half_s, span_s, fixed_s, acc_s, acc_neg;
  assign half_s  = $signed({3'b000, cm_q[15:1]});
  assign span_s  = $signed({2'b00, cm_q} + 18'd1);
  always_comb begin
    if (delta_q > half_s) begin
      fixed_s = delta_q - span_s;
    end else if (delta_q < -half_s) begin
      fixed_s = delta_q + span_s;
    end else begin
      fixed_s = delta_q;
    end
  end
  assign acc_s   = residue_q + fixed_s;
  assign acc_neg = -acc_s;

  // one restoring divide step per cycle
  logic [8:0] cpd_eff;
  logic [9:0] trial;
  logic       ge;
  assign cpd_eff = (cpd_q == 9'd0) ? 9'd1 : cpd_q;
  assign trial   = {rem_q, dq_q[DivW-1]};
  assign ge      = (trial >= {1'b0, cpd_eff});

  // sign and saturation of the quotient
  logic               neg_res;
  logic signed [15:0] det_sat;
  assign neg_res = neg_q ^ rev_q;
  always_comb begin
    if (neg_res) begin
      det_sat = (dq_q > 17'd32768) ? 16'sh8000 : $signed(16'(17'd0 - dq_q));
    end else begin
      det_sat = (dq_q > 17'd32767) ? 16'sh7FFF : $signed(dq_q[15:0]);
    end
  end

  // step selection
  logic [9:0] step;
  always_comb begin
    if (item_q.edit_current) begin
      step = item_q.coarse_mode ? cc_q : cf_q;
    end else begin
      step = item_q.coarse_mode ? {3'b000, vc_q} : {3'b000, vf_q};
    end
  end

  // final add and clamp
  logic               is_sample, tgt_curr, do_write;
  logic [9:0]         base, lo, hi, new_val, volt_next, curr_next;
  logic signed [27:0] sum_s;
  assign is_sample = (item_q.command == CMD_SAMPLE);
  assign tgt_curr  = is_sample ? item_q.edit_current : (item_q.command == CMD_LOAD_CURR);
  assign base      = tgt_curr ? curr_q : volt_q;
  assign lo        = tgt_curr ? CurrLo : VoltLo;
  assign hi        = tgt_curr ? CurrHi : VoltHi;
  assign sum_s     = is_sample ? ($signed({18'b0, base}) + 28'(product_q))
                               : $signed({18'b0, item_q.load_value});
  assign new_val   = clamp_set(sum_s, lo, hi);
  assign do_write  = (is_sample && (detents_q != 16'sd0)) ||
                     (item_q.command == CMD_LOAD_VOLT) ||
                     (item_q.command == CMD_LOAD_CURR);
  assign volt_next = (do_write && !tgt_curr) ? new_val : volt_q;
  assign curr_next = (do_write && tgt_curr) ? new_val : curr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pos_q <= '0;
      residue_q  <= '0;
      volt_q     <= VoltLo;
      curr_q     <= CurrLo;
    end else begin
      if (cmd_i.accept && in_sample_o) begin
        prev_pos_q <= in_data_i.position[PosW-1:0];
      end
      if (cmd_i.sat) begin
        residue_q <= neg_q ? -$signed({9'b0, rem_q}) : $signed({9'b0, rem_q});
      end
      if (cmd_i.commit) begin
        volt_q <= volt_next;
        curr_q <= curr_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q    <= in_data_i;
      delta_q   <= delta_d;
      detents_q <= '0;
    end
    if (cmd_i.prep) begin
      neg_q <= acc_s[17];
      dq_q  <= acc_s[17] ? acc_neg[DivW-1:0] : acc_s[DivW-1:0];
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? 9'(trial - {1'b0, cpd_eff}) : trial[8:0];
      dq_q  <= {dq_q[DivW-2:0], ge};
    end
    if (cmd_i.sat) begin
      detents_q <= det_sat;
    end
    if (cmd_i.mul) begin
      product_q <= 27'(detents_q) * 27'($signed({1'b0, step}));
    end
    if (cmd_i.commit) begin
      out_q.voltage_setpoint <= volt_next;
      out_q.current_setpoint <= curr_next;
      out_q.detent_count     <= detents_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/core/encoder_detent_setpoint.sv =====
// Top level of the encoder detent setpoint block.
//
//   channel | signals                          | direction
//   in      | in_valid_i in_ready_o in_data_i  | position samples and load commands
//   out     | out_valid_o out_ready_i out_data_o | setpoints and detents, one per item
//   cfg     | cfg_we_i cfg_idx_i cfg_wdata_i   | register writes, no wait
//
// A position sample goes from accept through wrap fix and the one-bit-per-cycle detent
// divider, then saturate, multiply, apply. Load commands and the unused command go
// straight to apply. The block takes one item at a time; the next item is taken once
// the result is presented, also while a result waits.
// A stalled output holds the block in its apply step until the result is taken.
// Reset restores register defaults, clears position and residue, setpoints go to min.
`timescale 1ns / 1ps

module encoder_detent_setpoint #(
  parameter int VOLT_MIN      = 0,
  parameter int VOLT_MAX      = 100,
  parameter int CURR_MIN      = 0,
  parameter int CURR_MAX      = 100,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  eds_pkg::in_item_t        in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output eds_pkg::out_item_t       out_data_o,
  input  logic                     cfg_we_i,
  input  logic [eds_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [eds_pkg::CfgW-1:0] cfg_wdata_i
);
  import eds_pkg::*;

  localparam int PosW = (POSITION_BITS < 16) ? POSITION_BITS : 16;

  dp_cmd_t cmd;
  logic    in_sample;

  eds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_sample_i (in_sample),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  eds_datapath #(
    .VOLT_MIN (VOLT_MIN),
    .VOLT_MAX (VOLT_MAX),
    .CURR_MIN (CURR_MIN),
    .CURR_MAX (CURR_MAX),
    .PosW     (PosW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .in_sample_o (in_sample),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while another is in work");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("committed result not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");
`endif

endmodule
